@@ hdl/htfd_pkg.sv @@
package htfd_pkg;

    // Byte positions inside one measurement frame.
    localparam logic [2:0] POS_T_MSB = 3'd0;
    localparam logic [2:0] POS_T_LSB = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_MSB = 3'd3;
    localparam logic [2:0] POS_H_LSB = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam logic [14:0] TEMP_SCALE  = 15'd17500;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;
    localparam logic [16:0] FULL_SCALE  = 17'd65535;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [13:0]        humidity_centi;
        logic [15:0]        raw_temperature;
        logic [15:0]        raw_humidity;
        logic               temp_crc_ok;
        logic               hum_crc_ok;
    } t_out_item;

    // One complete frame handed from the front end to the conversion pipeline.
    typedef struct packed {
        logic [15:0] raw_t;
        logic [15:0] raw_h;
        logic        t_ok;
        logic        h_ok;
    } t_job;

    // CRC-8, MSB first, no reflection, no final xor.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // floor(p / 65535) for p below 2^31: the quotient estimate p >> 16 is
    // short by at most one, because the remainder p[15:0] + q0 stays below
    // twice the divisor.
    function automatic logic [14:0] div_full_scale(input logic [30:0] p);
        logic [14:0] q0;
        logic [16:0] rem;
        q0  = p[30:16];
        rem = {1'b0, p[15:0]} + {2'b00, q0};
        return (rem >= FULL_SCALE) ? q0 + 15'd1 : q0;
    endfunction

endpackage

@@ hdl/humidity_temp_frame_decoder_top.sv @@
// Measurement frame decoder: push the six frame bytes (temperature MSB, LSB,
// CRC, humidity MSB, LSB, CRC) one request per cycle, with frame_start set
// on the first byte to resynchronize the byte position at any time. Every
// sixth byte yields one result request carrying temperature in hundredths
// of a degree C, humidity in hundredths of a percent, both raw words and
// both CRC-8 (polynomial 0x31, seed 0xFF) check flags; values are given
// even when a check fails. The input side takes one byte per cycle while
// full is low. The front end finishes a frame on the cycle its last byte
// is accepted and drops it into a job queue of QUEUE_DEPTH entries; the
// conversion pipeline (one multiply stage, one divide-by-65535 stage)
// moves each job from the job queue into the product register and from
// there into the output register, which shows the divided result.
// full rises only while the job queue holds QUEUE_DEPTH frames that the
// result side has not taken yet; then no byte is accepted until a result
// is popped.
module humidity_temp_frame_decoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  htfd_pkg::t_in_item  i_data,
    output logic                empty,
    input  logic                pop,
    output htfd_pkg::t_out_item o_data
);

    logic           in_accept;
    logic           job_valid;
    htfd_pkg::t_job front_job;
    htfd_pkg::t_job queue_job;
    logic           queue_empty;
    logic           queue_rd;

    // A byte request is taken whenever the job queue has room.
    assign in_accept = push && !full;

    // The front end tracks the byte position, the running CRC and the two
    // words; it raises job_valid on the last byte of each frame.
    htfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_item      (i_data),
        .o_job_valid (job_valid),
        .o_job       (front_job)
    );

    // The job queue decouples byte intake from the conversion pipeline so
    // that a stalled result side does not stop bytes until it is full.
    htfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (job_valid),
        .i_job   (front_job),
        .o_full  (full),
        .i_rd    (queue_rd),
        .o_empty (queue_empty),
        .o_job   (queue_job)
    );

    // The back end scales both words and holds the finished result in an
    // output register until it is popped.
    htfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (queue_empty),
        .i_job       (queue_job),
        .o_job_rd    (queue_rd),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_item      (o_data)
    );

endmodule

@@ hdl/htfd_front.sv @@
module htfd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  htfd_pkg::t_in_item i_item,
    output logic               o_job_valid,
    output htfd_pkg::t_job     o_job
);

    logic [2:0]  r_pos;
    logic [2:0]  n_pos;
    logic [7:0]  r_crc;
    logic [7:0]  n_crc;
    logic [15:0] r_temp_word;
    logic [15:0] n_temp_word;
    logic [15:0] r_hum_word;
    logic [15:0] n_hum_word;
    logic        r_temp_ok;
    logic        n_temp_ok;
    logic [2:0]  pos;
    logic [7:0]  crc_step;

    always_comb begin
        pos = r_pos;
        if (i_item.frame_start || r_pos > htfd_pkg::POS_H_CRC) begin
            pos = htfd_pkg::POS_T_MSB;
        end
    end

    always_comb begin
        crc_step = htfd_pkg::crc8_byte(r_crc, i_item.data_byte);
        if (pos == htfd_pkg::POS_T_MSB || pos == htfd_pkg::POS_H_MSB) begin
            crc_step = htfd_pkg::crc8_byte(htfd_pkg::CRC_INIT, i_item.data_byte);
        end
    end

    always_comb begin
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_temp_word = r_temp_word;
        n_hum_word  = r_hum_word;
        n_temp_ok   = r_temp_ok;
        o_job_valid = 1'b0;
        if (i_accept) begin
            case (pos)
                htfd_pkg::POS_T_MSB: begin
                    n_temp_word = {i_item.data_byte, 8'h00};
                    n_crc       = crc_step;
                    n_pos       = htfd_pkg::POS_T_LSB;
                end
                htfd_pkg::POS_T_LSB: begin
                    n_temp_word = {r_temp_word[15:8], i_item.data_byte};
                    n_crc       = crc_step;
                    n_pos       = htfd_pkg::POS_T_CRC;
                end
                htfd_pkg::POS_T_CRC: begin
                    n_temp_ok = (r_crc == i_item.data_byte);
                    n_crc     = htfd_pkg::CRC_INIT;
                    n_pos     = htfd_pkg::POS_H_MSB;
                end
                htfd_pkg::POS_H_MSB: begin
                    n_hum_word = {i_item.data_byte, 8'h00};
                    n_crc      = crc_step;
                    n_pos      = htfd_pkg::POS_H_LSB;
                end
                htfd_pkg::POS_H_LSB: begin
                    n_hum_word = {r_hum_word[15:8], i_item.data_byte};
                    n_crc      = crc_step;
                    n_pos      = htfd_pkg::POS_H_CRC;
                end
                default: begin
                    o_job_valid = 1'b1;
                    n_crc       = htfd_pkg::CRC_INIT;
                    n_pos       = htfd_pkg::POS_T_MSB;
                end
            endcase
        end
    end

    assign o_job.raw_t = r_temp_word;
    assign o_job.raw_h = r_hum_word;
    assign o_job.t_ok  = r_temp_ok;
    assign o_job.h_ok  = (r_crc == i_item.data_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= htfd_pkg::POS_T_MSB;
            r_crc <= htfd_pkg::CRC_INIT;
        end else begin
            r_pos <= n_pos;
            r_crc <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_word <= '0;
            r_hum_word  <= '0;
            r_temp_ok   <= 1'b0;
        end else begin
            r_temp_word <= n_temp_word;
            r_hum_word  <= n_hum_word;
            r_temp_ok   <= n_temp_ok;
        end
    end

endmodule

@@ hdl/htfd_queue.sv @@
module htfd_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  htfd_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_rd,
    output logic           o_empty,
    output htfd_pkg::t_job o_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    htfd_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           wr_en;
    logic           rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("job queue count exceeds its depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && !rd_en) |=> r_count == $past(r_count) + 1'b1)
        else $error("job queue count did not grow on a lone write");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CW'(DEPTH)) |-> r_wr_ptr == r_rd_ptr)
        else $error("job queue pointers disagree with an empty or full count");

endmodule

@@ hdl/htfd_back.sv @@
module htfd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_empty,
    input  htfd_pkg::t_job      i_job,
    output logic                o_job_rd,
    output logic                o_empty,
    input  logic                i_pop,
    output htfd_pkg::t_out_item o_item
);

    logic                r_s1_valid;
    logic [30:0]         r_s1_tprod;
    logic [29:0]         r_s1_hprod;
    htfd_pkg::t_job      r_s1_job;
    logic                r_out_valid;
    htfd_pkg::t_out_item r_out;
    logic                out_ready;
    logic                s1_ready;
    logic [14:0]         t_quot;
    logic [14:0]         h_quot;
    logic [15:0]         t_centi;

    assign out_ready = !r_out_valid || i_pop;
    assign s1_ready  = !r_s1_valid || out_ready;
    assign o_job_rd  = !i_job_empty && s1_ready;
    assign o_empty   = !r_out_valid;
    assign o_item    = r_out;

    assign t_quot  = htfd_pkg::div_full_scale(r_s1_tprod);
    assign h_quot  = htfd_pkg::div_full_scale({1'b0, r_s1_hprod});
    assign t_centi = {1'b0, t_quot} - htfd_pkg::TEMP_OFFSET;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= !i_job_empty;
            end
            if (out_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_rd) begin
            r_s1_job   <= i_job;
            r_s1_tprod <= 31'(i_job.raw_t) * 31'(htfd_pkg::TEMP_SCALE);
            r_s1_hprod <= 30'(i_job.raw_h) * 30'(htfd_pkg::HUM_SCALE);
        end
        if (r_s1_valid && out_ready) begin
            r_out.temperature_centi <= t_centi[14:0];
            r_out.humidity_centi    <= h_quot[13:0];
            r_out.raw_temperature   <= r_s1_job.raw_t;
            r_out.raw_humidity      <= r_s1_job.raw_h;
            r_out.temp_crc_ok       <= r_s1_job.t_ok;
            r_out.hum_crc_ok        <= r_s1_job.h_ok;
        end
    end

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=> r_out_valid)
        else $error("result dropped without a pop");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_ready) |=> r_s1_valid && $stable(r_s1_job))
        else $error("product stage changed while stalled");

    a_no_read_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_ready) |-> !o_job_rd)
        else $error("job read while the product stage was stalled");

endmodule
